[rtl/core/brp_pkg.sv]
// Shared types, codes and helpers for the board record parser.
package brp_pkg;

  // Result kinds
  localparam logic [2:0] KindMac   = 3'd0;
  localparam logic [2:0] KindBaud  = 3'd1;
  localparam logic [2:0] KindMem   = 3'd2;
  localparam logic [2:0] KindClock = 3'd3;
  localparam logic [2:0] KindEnd   = 3'd4;

  // Key kinds (second letter is checked against these)
  localparam logic [1:0] KeyMac   = 2'd0;
  localparam logic [1:0] KeyBaud  = 2'd1;
  localparam logic [1:0] KeyMem   = 2'd2;
  localparam logic [1:0] KeyClock = 2'd3;

  // Characters of interest
  localparam logic [7:0] ChNul     = 8'h00;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChFill    = 8'hFF;
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChOne     = 8'h31;
  localparam logic [7:0] ChUpA     = 8'h41;
  localparam logic [7:0] ChUpB     = 8'h42;
  localparam logic [7:0] ChUpD     = 8'h44;
  localparam logic [7:0] ChUpE     = 8'h45;
  localparam logic [7:0] ChUpF     = 8'h46;
  localparam logic [7:0] ChUpH     = 8'h48;
  localparam logic [7:0] ChUpS     = 8'h53;
  localparam logic [7:0] ChUpZ     = 8'h5A;
  localparam logic [7:0] ChLowA    = 8'h61;
  localparam logic [7:0] ChLowF    = 8'h66;

  // Scale factors
  localparam logic [31:0] HzPerMhz  = 32'd1000000;
  localparam logic [31:0] BaudUnit  = 32'd100;
  localparam int unsigned MbShift   = 20;
  localparam int unsigned MacDigits = 12;
  localparam logic [9:0]  LimitReset = 10'd50;

  // Parser phase, one-hot
  typedef enum logic [7:0] {
    PhFirst = 8'b0000_0001,
    PhLater = 8'b0000_0010,
    PhKey2  = 8'b0000_0100,
    PhSep   = 8'b0000_1000,
    PhValue = 8'b0001_0000,
    PhDiv   = 8'b0010_0000,
    PhSkip  = 8'b0100_0000,
    PhDone  = 8'b1000_0000
  } phase_e;

  // Arithmetic sequencer, one-hot
  typedef enum logic [5:0] {
    SeqIdle    = 6'b00_0001,
    SeqDiv     = 6'b00_0010,
    SeqMulQ    = 6'b00_0100,
    SeqMulHz   = 6'b00_1000,
    SeqMulBaud = 6'b01_0000,
    SeqEmit    = 6'b10_0000
  } seq_e;

  // Work a byte hands to the sequencer
  typedef enum logic [1:0] {
    JobNone  = 2'd0,
    JobEmit  = 2'd1,
    JobBaud  = 2'd2,
    JobClock = 2'd3
  } job_e;

  // Hex digit value; other bytes count as (c - '0') mod 256
  function automatic logic [7:0] hex_value(logic [7:0] c);
    logic [7:0] v;
    if (c inside {[ChUpA:ChUpF]}) begin
      v = c - ChUpA + 8'd10;
    end else if (c inside {[ChLowA:ChLowF]}) begin
      v = c - ChLowA + 8'd10;
    end else begin
      v = c - ChZero;
    end
    return v;
  endfunction

  // Expected second key letter for each key kind
  function automatic logic [7:0] second_key(logic [1:0] kk);
    logic [7:0] k;
    case (kk)
      KeyMac:   k = ChUpA;
      KeyBaud:  k = ChUpB;
      KeyMem:   k = ChOne;
      KeyClock: k = ChUpZ;
      default:  k = ChUpA;
    endcase
    return k;
  endfunction

endpackage

[rtl/core/board_record_parser_core.sv]
// Board record parser: byte-wise record decoder with a shared divide/multiply sequencer.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, data_byte_i,      | into block
//          | table_start_i                             |
//  out     | out_valid_o, out_stall_i, result_kind_o,  | out of block
//          | main_value_o, bus_value_o                 |
//  cfg     | cfg_we_i, cfg_wdata_i (bus_limit_mhz)     | into block
//
// A byte that yields no result leaves the sequencer idle; the next byte can be taken in the following cycle.
// MAC, memory size and end-of-table results go straight to the emit step; baud passes the baud multiply.
// Clock results pass the Hz multiply, or with a nonzero divisor a restoring divider first retires
// one quotient bit per cycle, then the one shared 32x32 multiplier runs twice.
// Input stalls while the sequencer is busy; a result waits in the output register
// while the next bytes are parsed, and the sequencer holds in its emit step if it is full and stalled.
// rst_ni clears the parser, the sequencer and the limit register (to 50) at once.
module board_record_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        table_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  result_kind_o,
  output logic [47:0] main_value_o,
  output logic [31:0] bus_value_o,
  input  logic        cfg_we_i,
  input  logic [9:0]  cfg_wdata_i
);

  // Parser state
  brp_pkg::phase_e phase_q, phase_d;
  logic [1:0]  key_kind_q, key_kind_d;
  logic [31:0] acc_q, acc_d;
  logic [47:0] mac_q, mac_d;
  logic [3:0]  hex_cnt_q, hex_cnt_d;
  logic [3:0]  hi_nib_q, hi_nib_d;
  logic [31:0] divisor_q, divisor_d;
  logic        started_q, started_d;

  // Current view of parser state (table start clears it)
  brp_pkg::phase_e cur_phase;
  logic [1:0]  cur_kk;
  logic [31:0] cur_acc;
  logic [47:0] cur_mac;
  logic [3:0]  cur_hex_cnt;
  logic [3:0]  cur_hi;
  logic [31:0] cur_div;
  logic        cur_started;

  // Job from this byte
  brp_pkg::job_e job;
  logic [2:0]  job_kind;
  logic [47:0] job_main;

  // Sequencer and shared unit
  brp_pkg::seq_e seq_q;
  logic [31:0] num_q;
  logic [31:0] quo_q;
  logic [31:0] rem_q;
  logic [4:0]  div_cnt_q;
  logic [2:0]  pend_kind_q;
  logic [47:0] pend_main_q;
  logic [31:0] pend_bus_q;
  logic [9:0]  limit_q;

  logic        in_acc;
  logic        emit_fire;
  logic [7:0]  c;
  logic        ends_rec;
  logic [7:0]  hv;
  logic [7:0]  mac_byte;
  logic [4:0]  hex_next;
  logic [32:0] rem_shift;
  logic [32:0] rem_diff;
  logic        take;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] prod;

  // Output register
  logic        out_valid_q;
  logic [2:0]  out_kind_q;
  logic [47:0] out_main_q;
  logic [31:0] out_bus_q;

  assign in_stall_o = (seq_q != brp_pkg::SeqIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign c          = data_byte_i;
  assign ends_rec   = (c == brp_pkg::ChNewline) || (c == brp_pkg::ChFill);
  assign emit_fire  = (seq_q == brp_pkg::SeqEmit) && (!out_valid_q || !out_stall_i);

  // Apply table start before parsing the byte
  always_comb begin
    if (table_start_i) begin
      cur_phase   = brp_pkg::PhFirst;
      cur_kk      = brp_pkg::KeyMac;
      cur_acc     = '0;
      cur_mac     = '0;
      cur_hex_cnt = '0;
      cur_hi      = '0;
      cur_div     = '0;
      cur_started = 1'b0;
    end else begin
      cur_phase   = phase_q;
      cur_kk      = key_kind_q;
      cur_acc     = acc_q;
      cur_mac     = mac_q;
      cur_hex_cnt = hex_cnt_q;
      cur_hi      = hi_nib_q;
      cur_div     = divisor_q;
      cur_started = started_q;
    end
  end

  assign hv       = brp_pkg::hex_value(c);
  assign mac_byte = {cur_hi, 4'b0000} + hv;
  assign hex_next = {1'b0, cur_hex_cnt} + 5'd1;

  // Parse one byte
  always_comb begin
    phase_d    = cur_phase;
    key_kind_d = cur_kk;
    acc_d      = cur_acc;
    mac_d      = cur_mac;
    hex_cnt_d  = cur_hex_cnt;
    hi_nib_d   = cur_hi;
    divisor_d  = cur_div;
    started_d  = cur_started;
    job        = brp_pkg::JobNone;
    job_kind   = brp_pkg::KindEnd;
    job_main   = '0;
    case (cur_phase)
      brp_pkg::PhFirst, brp_pkg::PhLater: begin
        if (cur_phase == brp_pkg::PhLater &&
            (c == brp_pkg::ChNul || c == brp_pkg::ChFill)) begin
          phase_d  = brp_pkg::PhDone;
          job      = brp_pkg::JobEmit;
          job_kind = brp_pkg::KindEnd;
        end else if (ends_rec) begin
          phase_d = brp_pkg::PhLater;
        end else if (c == brp_pkg::ChUpE) begin
          key_kind_d = brp_pkg::KeyMac;
          phase_d    = brp_pkg::PhKey2;
        end else if (c == brp_pkg::ChUpS) begin
          key_kind_d = brp_pkg::KeyBaud;
          phase_d    = brp_pkg::PhKey2;
        end else if (c == brp_pkg::ChUpD) begin
          key_kind_d = brp_pkg::KeyMem;
          phase_d    = brp_pkg::PhKey2;
        end else if (c == brp_pkg::ChUpH) begin
          key_kind_d = brp_pkg::KeyClock;
          phase_d    = brp_pkg::PhKey2;
        end else begin
          phase_d = brp_pkg::PhSkip;
        end
      end
      brp_pkg::PhKey2: begin
        if (ends_rec) begin
          phase_d = brp_pkg::PhLater;
        end else if (c == brp_pkg::second_key(cur_kk)) begin
          phase_d = brp_pkg::PhSep;
        end else begin
          phase_d = brp_pkg::PhSkip;
        end
      end
      brp_pkg::PhSep: begin
        if (ends_rec) begin
          phase_d = brp_pkg::PhLater;
        end else begin
          phase_d   = brp_pkg::PhValue;
          acc_d     = '0;
          mac_d     = '0;
          hex_cnt_d = '0;
          hi_nib_d  = '0;
          divisor_d = '0;
          started_d = 1'b0;
        end
      end
      brp_pkg::PhValue: begin
        if (cur_kk == brp_pkg::KeyMac) begin
          if (ends_rec) begin
            phase_d = brp_pkg::PhLater;
          end else begin
            if (!cur_hex_cnt[0]) begin
              hi_nib_d = hv[3:0];
            end else begin
              mac_d = {cur_mac[39:0], mac_byte};
            end
            hex_cnt_d = hex_next[3:0];
            if (hex_next >= 5'(brp_pkg::MacDigits)) begin
              phase_d  = brp_pkg::PhSkip;
              job      = brp_pkg::JobEmit;
              job_kind = brp_pkg::KindMac;
              job_main = cur_hex_cnt[0] ? {cur_mac[39:0], mac_byte} : cur_mac;
            end
          end
        end else if (ends_rec) begin
          phase_d = brp_pkg::PhLater;
          case (cur_kk)
            brp_pkg::KeyBaud: job = brp_pkg::JobBaud;
            brp_pkg::KeyMem: begin
              job      = brp_pkg::JobEmit;
              job_kind = brp_pkg::KindMem;
              job_main = {16'b0, cur_acc[31-brp_pkg::MbShift:0], {brp_pkg::MbShift{1'b0}}};
            end
            default: job = brp_pkg::JobClock;
          endcase
        end else if (cur_kk == brp_pkg::KeyClock && cur_started && c == brp_pkg::ChSlash) begin
          phase_d = brp_pkg::PhDiv;
        end else begin
          acc_d     = {cur_acc[28:0], 3'b000} + {cur_acc[30:0], 1'b0}
                      + ({24'b0, c} - {24'b0, brp_pkg::ChZero});
          started_d = 1'b1;
        end
      end
      brp_pkg::PhDiv: begin
        divisor_d = {24'b0, c} - {24'b0, brp_pkg::ChZero};
        phase_d   = ends_rec ? brp_pkg::PhLater : brp_pkg::PhSkip;
        job       = brp_pkg::JobClock;
      end
      brp_pkg::PhSkip: begin
        if (ends_rec) phase_d = brp_pkg::PhLater;
      end
      default: ;
    endcase
  end

  // Hold parser state between accepted bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= brp_pkg::PhFirst;
      key_kind_q <= brp_pkg::KeyMac;
      acc_q      <= '0;
      mac_q      <= '0;
      hex_cnt_q  <= '0;
      hi_nib_q   <= '0;
      divisor_q  <= '0;
      started_q  <= 1'b0;
    end else if (in_acc) begin
      phase_q    <= phase_d;
      key_kind_q <= key_kind_d;
      acc_q      <= acc_d;
      mac_q      <= mac_d;
      hex_cnt_q  <= hex_cnt_d;
      hi_nib_q   <= hi_nib_d;
      divisor_q  <= divisor_d;
      started_q  <= started_d;
    end
  end

  // Write the limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= brp_pkg::LimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // Divider step: one quotient bit per cycle
  assign rem_shift = {rem_q, quo_q[31]};
  assign rem_diff  = rem_shift - {1'b0, divisor_q};
  assign take      = !rem_diff[32];

  // Shared multiplier, low 32 bits kept
  always_comb begin
    case (seq_q)
      brp_pkg::SeqMulQ: begin
        mul_a = quo_q;
        mul_b = divisor_q;
      end
      brp_pkg::SeqMulBaud: begin
        mul_a = num_q;
        mul_b = brp_pkg::BaudUnit;
      end
      default: begin
        mul_a = num_q;
        mul_b = brp_pkg::HzPerMhz;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  // Advance the sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= brp_pkg::SeqIdle;
    end else begin
      case (seq_q)
        brp_pkg::SeqIdle: begin
          if (in_acc) begin
            case (job)
              brp_pkg::JobEmit: seq_q <= brp_pkg::SeqEmit;
              brp_pkg::JobBaud: seq_q <= brp_pkg::SeqMulBaud;
              brp_pkg::JobClock: begin
                seq_q <= (divisor_d != '0) ? brp_pkg::SeqDiv : brp_pkg::SeqMulHz;
              end
              default: seq_q <= brp_pkg::SeqIdle;
            endcase
          end
        end
        brp_pkg::SeqDiv: begin
          if (div_cnt_q == '1) seq_q <= brp_pkg::SeqMulQ;
        end
        brp_pkg::SeqMulQ:    seq_q <= brp_pkg::SeqMulHz;
        brp_pkg::SeqMulHz:   seq_q <= brp_pkg::SeqEmit;
        brp_pkg::SeqMulBaud: seq_q <= brp_pkg::SeqEmit;
        brp_pkg::SeqEmit: begin
          if (emit_fire) seq_q <= brp_pkg::SeqIdle;
        end
        default: seq_q <= brp_pkg::SeqIdle;
      endcase
    end
  end

  // Datapath registers of the sequencer
  always_ff @(posedge clk_i) begin
    case (seq_q)
      brp_pkg::SeqIdle: begin
        num_q       <= acc_d;
        quo_q       <= acc_d;
        rem_q       <= '0;
        div_cnt_q   <= '0;
        pend_kind_q <= job_kind;
        pend_main_q <= job_main;
        pend_bus_q  <= '0;
      end
      brp_pkg::SeqDiv: begin
        rem_q     <= take ? rem_diff[31:0] : rem_shift[31:0];
        quo_q     <= {quo_q[30:0], take};
        div_cnt_q <= div_cnt_q + 5'd1;
      end
      brp_pkg::SeqMulQ: begin
        num_q <= prod;
      end
      brp_pkg::SeqMulHz: begin
        pend_kind_q <= brp_pkg::KindClock;
        pend_main_q <= {16'b0, prod};
        pend_bus_q  <= (num_q > {22'b0, limit_q}) ? {1'b0, prod[31:1]} : prod;
      end
      brp_pkg::SeqMulBaud: begin
        pend_kind_q <= brp_pkg::KindBaud;
        pend_main_q <= {16'b0, prod};
        pend_bus_q  <= '0;
      end
      default: ;
    endcase
  end

  // Load and drop the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_kind_q <= pend_kind_q;
      out_main_q <= pend_main_q;
      out_bus_q  <= pend_bus_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_kind_q;
  assign main_value_o  = out_main_q;
  assign bus_value_o   = out_bus_q;

  // A new result only comes from the emit step
  a_emit_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(seq_q == brp_pkg::SeqEmit))
    else $error("output loaded outside emit step");

  // The divider never runs with a zero divisor
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == brp_pkg::SeqDiv) |-> (divisor_q != '0))
    else $error("divide step with zero divisor");

  // Only clock results carry a bus value
  a_bus_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q != brp_pkg::KindClock) |-> (out_bus_q == '0))
    else $error("bus value on non-clock result");

  // Hex count stays within one MAC
  a_hex_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hex_cnt_q <= 4'(brp_pkg::MacDigits))
    else $error("hex count out of range");

  // No byte is taken while the divider runs, and the divider does not leave early
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == brp_pkg::SeqDiv && div_cnt_q != '1) |=> (seq_q == brp_pkg::SeqDiv) && in_stall_o)
    else $error("divider left early");

endmodule
